[hw/rtl/nsp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared types, character codes and result codes of the NMEA sentence parser.
// ----------------------------------------------------------------------------
package nsp_pkg;

    // sentence characters
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] NUL_BYTE    = 8'h00;

    // hex digit conversion
    localparam logic [7:0]  CASE_MASK   = 8'hDF;
    localparam logic [31:0] ALPHA_BIAS  = 32'h0000_0037;
    localparam logic [31:0] DIGIT_BIAS  = 32'h0000_0030;

    // position limits
    localparam logic [5:0] FIELD_MAX    = 6'd63;
    localparam logic [6:0] POS_MAX      = 7'd127;
    localparam logic [6:0] TYPE_POS_LO  = 7'd3;
    localparam logic [6:0] TYPE_POS_MID = 7'd4;
    localparam logic [6:0] TYPE_POS_HI  = 7'd5;

    // sentence type letters, first letter in the low byte
    localparam logic [23:0] CODE_GGA = {8'h41, 8'h47, 8'h47};
    localparam logic [23:0] CODE_GSV = {8'h56, 8'h53, 8'h47};
    localparam logic [23:0] CODE_VTG = {8'h47, 8'h54, 8'h56};
    localparam logic [23:0] CODE_RMC = {8'h43, 8'h4D, 8'h52};
    localparam logic [23:0] CODE_GSA = {8'h41, 8'h53, 8'h47};

    // event codes
    localparam logic [2:0] EV_CHAR  = 3'd0;
    localparam logic [2:0] EV_START = 3'd1;
    localparam logic [2:0] EV_FIELD = 3'd2;
    localparam logic [2:0] EV_STAR  = 3'd3;
    localparam logic [2:0] EV_VERD  = 3'd4;
    localparam logic [2:0] EV_NL    = 3'd5;

    // sentence type codes
    localparam logic [2:0] STYPE_NONE = 3'd0;
    localparam logic [2:0] STYPE_GGA  = 3'd1;
    localparam logic [2:0] STYPE_GSV  = 3'd2;
    localparam logic [2:0] STYPE_VTG  = 3'd3;
    localparam logic [2:0] STYPE_RMC  = 3'd4;
    localparam logic [2:0] STYPE_GSA  = 3'd5;

    // handler codes
    localparam logic [1:0] HND_NONE = 2'd0;
    localparam logic [1:0] HND_GGA  = 2'd1;
    localparam logic [1:0] HND_VTG  = 2'd2;
    localparam logic [1:0] HND_RMC  = 2'd3;

    // parser state carried from word to word
    typedef struct packed {
        logic [7:0]  running_sum;
        logic        in_checksum_part;
        logic [5:0]  field_count;
        logic [6:0]  char_position;
        logic [23:0] type_letters;
        logic [31:0] hex_accumulator;
        logic        hex_stopped;
        logic [1:0]  current_handler;
        logic        verdict;
    } nsp_state_t;

    // one result word
    typedef struct packed {
        logic [2:0] event_res;
        logic [5:0] field_index;
        logic [2:0] sentence_type;
        logic [1:0] handler;
        logic       checksum_ok;
        logic [7:0] out_byte;
    } nsp_result_t;

    // value of one character as a hex digit, no range check
    function automatic logic [31:0] hex_digit(input logic [7:0] c);
        logic [31:0] v;
        if (c > CHAR_NINE)
        begin
            v = {24'd0, c & CASE_MASK} - ALPHA_BIAS;
        end
        else
        begin
            v = {24'd0, c} - DIGIT_BIAS;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/nmea_sentence_byte_parser_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_sentence_byte_parser_core
// NMEA 0183 character parser with XOR checksum check and type detection.
// ----------------------------------------------------------------------------
// One ASCII character enters per word on the slave side and one result word
// leaves on the master side for each. The parser state is updated by a single
// level of logic as the word is taken, and the result sits in an output
// register; a new word can be taken every cycle as long as m_tready stays
// high. While a result waits for m_tready, s_tready is low and the next word
// is held off until that result is taken. '$' restarts a sentence, ',' ends
// a field, '*' opens the checksum section and '\r' compares the hex text
// after '*' with the running XOR; the verdict is in checksum_ok.
// ----------------------------------------------------------------------------
module nmea_sentence_byte_parser_core
    import nsp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input character stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [5:0] field_index, [8:6] sentence_type,
                                        // [10:9] handler, [11] checksum_ok,
                                        // [19:12] out_byte, [23:20] zero
    output logic [2:0]       m_tuser    // [2:0] event_res
);

    nsp_state_t  state_reg;
    nsp_state_t  state_next;
    nsp_result_t step_res;
    nsp_result_t res_reg;
    logic        valid_reg;
    logic        s_accept;

    // word handshake
    assign s_tready = !valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // per-character logic
    nsp_step u_step (
        .in_byte   (s_tdata),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .result    (step_res)
    );

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (s_accept)
        begin
            state_reg <= state_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.event_res;
    assign m_tdata  = {4'd0, res_reg.out_byte, res_reg.checksum_ok, res_reg.handler,
                       res_reg.sentence_type, res_reg.field_index};

    // checks
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_accept |=> $stable(state_reg))
        else $error("parser state changed without an accepted word");

    a_handler_comma: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && step_res.event_res != EV_FIELD |=> $stable(state_reg.current_handler))
        else $error("handler changed outside a field end");

    a_start_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == EV_START |-> !res_reg.checksum_ok && res_reg.field_index == 6'd0)
        else $error("sentence start did not clear verdict and field index");

    a_type_field0: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_reg.sentence_type != STYPE_NONE |->
            m_tuser == EV_FIELD && res_reg.field_index == 6'd0)
        else $error("sentence type reported outside the end of field zero");

endmodule
`default_nettype wire

[hw/rtl/nsp_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsp_step
// Per-character next-state and result logic of the NMEA sentence parser.
// ----------------------------------------------------------------------------
module nsp_step
    import nsp_pkg::*;
(
    input  wire logic [7:0]  in_byte,
    input  wire nsp_state_t  state_cur,
    output nsp_state_t       state_nxt,
    output nsp_result_t      result
);

    // store one character into the field buffer
    function automatic nsp_state_t store_char(input nsp_state_t s, input logic [7:0] c);
        nsp_state_t r;
        r = s;
        if (s.char_position == TYPE_POS_LO)
        begin
            r.type_letters[7:0] = c;
        end
        else if (s.char_position == TYPE_POS_MID)
        begin
            r.type_letters[15:8] = c;
        end
        else if (s.char_position == TYPE_POS_HI)
        begin
            r.type_letters[23:16] = c;
        end
        if (s.char_position < POS_MAX)
        begin
            r.char_position = s.char_position + 7'd1;
        end
        if (!s.hex_stopped)
        begin
            if (c == NUL_BYTE)
            begin
                r.hex_stopped = 1'b1;
            end
            else
            begin
                r.hex_accumulator = {s.hex_accumulator[27:0], 4'h0} + hex_digit(c);
            end
        end
        return r;
    endfunction

    // empty the field buffer
    function automatic nsp_state_t clear_buf(input nsp_state_t s);
        nsp_state_t r;
        r = s;
        r.char_position   = '0;
        r.type_letters    = '0;
        r.hex_accumulator = '0;
        r.hex_stopped     = 1'b0;
        return r;
    endfunction

    // saturating field advance
    function automatic logic [5:0] field_inc(input logic [5:0] f);
        return (f < FIELD_MAX) ? f + 6'd1 : f;
    endfunction

    // sentence type lookup
    function automatic logic [2:0] match_type(input logic [23:0] t);
        logic [2:0] m;
        case (t)
            CODE_GGA: m = STYPE_GGA;
            CODE_GSV: m = STYPE_GSV;
            CODE_VTG: m = STYPE_VTG;
            CODE_RMC: m = STYPE_RMC;
            CODE_GSA: m = STYPE_GSA;
            default:  m = STYPE_NONE;
        endcase
        return m;
    endfunction

    // character decode and state update
    always_comb
    begin
        nsp_state_t s;
        logic [2:0] ev;
        logic [5:0] idx;
        logic [2:0] stype;
        s     = state_cur;
        ev    = EV_CHAR;
        idx   = state_cur.field_count;
        stype = STYPE_NONE;
        unique case (in_byte)
            CHAR_DOLLAR:
            begin
                s.running_sum      = '0;
                s.field_count      = '0;
                s.verdict          = 1'b0;
                s.in_checksum_part = 1'b0;
                s = clear_buf(s);
                s = store_char(s, in_byte);
                ev  = EV_START;
                idx = '0;
            end
            CHAR_STAR:
            begin
                s.in_checksum_part = 1'b1;
                s.field_count      = field_inc(state_cur.field_count);
                s = clear_buf(s);
                ev  = EV_STAR;
                idx = s.field_count;
            end
            CHAR_LF:
            begin
                ev = EV_NL;
            end
            CHAR_CR:
            begin
                s.verdict     = (state_cur.hex_accumulator == {24'd0, state_cur.running_sum});
                s.running_sum = '0;
                ev = EV_VERD;
            end
            CHAR_COMMA:
            begin
                s.running_sum = state_cur.running_sum ^ in_byte;
                if (state_cur.field_count == 6'd0)
                begin
                    stype = match_type(state_cur.type_letters);
                    if (stype == STYPE_GGA)
                    begin
                        s.current_handler = HND_GGA;
                    end
                    else if (stype == STYPE_VTG)
                    begin
                        s.current_handler = HND_VTG;
                    end
                    else if (stype == STYPE_RMC)
                    begin
                        s.current_handler = HND_RMC;
                    end
                end
                s.field_count = field_inc(state_cur.field_count);
                s = clear_buf(s);
                ev = EV_FIELD;
            end
            default:
            begin
                s = store_char(s, in_byte);
                if (!state_cur.in_checksum_part)
                begin
                    s.running_sum = state_cur.running_sum ^ in_byte;
                end
            end
        endcase
        state_nxt            = s;
        result.event_res     = ev;
        result.field_index   = idx;
        result.sentence_type = stype;
        result.handler       = s.current_handler;
        result.checksum_ok   = s.verdict;
        result.out_byte      = in_byte;
    end

endmodule
`default_nettype wire

[test/tb_nmea_sentence_byte_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nmea_sentence_byte_parser_core
// Streams NMEA characters into the parser and checks every result word against
// a cycle-free predictor of the parser state: events, field index, type match,
// handler choice and checksum verdict. Directed bytes come first, then random
// sentences with good and bad checksums, noise and broken lines, under random
// idling on both sides and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_byte_parser_core;
    import nsp_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;

    // traffic shaping
    bit          quiet     = 1'b0;
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;

    // bookkeeping
    int unsigned n_sent     = 0;
    int unsigned n_errors   = 0;
    int unsigned idle_count = 0;
    nsp_result_t pending_results[$];
    nsp_result_t want;
    logic [7:0]  line_q[$];
    string       field_chars = "0123456789.-NEWS";

    // predicted parser state
    logic [7:0]  xor_sum    = 8'h00;
    logic        star_seen  = 1'b0;
    logic [5:0]  field_no   = 6'd0;
    logic [6:0]  buf_pos    = 7'd0;
    logic [23:0] letters    = 24'd0;
    logic [31:0] hex_val    = 32'd0;
    logic        hex_frozen = 1'b0;
    logic [1:0]  hnd        = HND_NONE;
    logic        verdict_q  = 1'b0;

    nmea_sentence_byte_parser_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // field buffer restarts on '$', ',' and '*'
    function automatic void restart_buffer();
        buf_pos    = 7'd0;
        letters    = 24'd0;
        hex_val    = 32'd0;
        hex_frozen = 1'b0;
    endfunction

    function automatic void bump_field();
        if (field_no != FIELD_MAX)
        begin
            field_no = field_no + 6'd1;
        end
    endfunction

    // store one character: type letters, position and running hex value
    function automatic void keep_char(input logic [7:0] c);
        logic [31:0] nib;
        if (buf_pos >= TYPE_POS_LO && buf_pos <= TYPE_POS_HI)
        begin
            letters[8 * (buf_pos - TYPE_POS_LO) +: 8] = c;
        end
        if (buf_pos != POS_MAX)
        begin
            buf_pos = buf_pos + 7'd1;
        end
        if (!hex_frozen)
        begin
            if (c == NUL_BYTE)
            begin
                hex_frozen = 1'b1;
            end
            else
            begin
                // letters fold to upper case, no range check on the digit
                nib = (c > CHAR_NINE) ? ({24'd0, c & CASE_MASK} - 32'h37)
                                      : ({24'd0, c} - 32'h30);
                hex_val = (hex_val << 4) + nib;
            end
        end
    endfunction

    // advance the parser by one character and return its result word
    function automatic nsp_result_t parse_char(input logic [7:0] c);
        nsp_result_t r;
        r               = '0;
        r.event_res     = EV_CHAR;
        r.sentence_type = STYPE_NONE;
        r.out_byte      = c;
        r.field_index   = field_no;
        case (c)
            CHAR_DOLLAR:
            begin
                xor_sum   = 8'h00;
                field_no  = 6'd0;
                verdict_q = 1'b0;
                star_seen = 1'b0;
                restart_buffer();
                keep_char(c);
                r.event_res = EV_START;
            end
            CHAR_STAR:
            begin
                star_seen = 1'b1;
                bump_field();
                restart_buffer();
                r.event_res = EV_STAR;
            end
            CHAR_LF:
            begin
                r.event_res = EV_NL;
            end
            CHAR_CR:
            begin
                verdict_q   = (hex_val == {24'd0, xor_sum});
                xor_sum     = 8'h00;
                r.event_res = EV_VERD;
            end
            CHAR_COMMA:
            begin
                xor_sum = xor_sum ^ c;
                // only the comma that ends the header field matches a type
                if (field_no == 6'd0)
                begin
                    case (letters)
                        CODE_GGA: r.sentence_type = STYPE_GGA;
                        CODE_GSV: r.sentence_type = STYPE_GSV;
                        CODE_VTG: r.sentence_type = STYPE_VTG;
                        CODE_RMC: r.sentence_type = STYPE_RMC;
                        CODE_GSA: r.sentence_type = STYPE_GSA;
                        default:  r.sentence_type = STYPE_NONE;
                    endcase
                    if (r.sentence_type == STYPE_GGA)
                    begin
                        hnd = HND_GGA;
                    end
                    else if (r.sentence_type == STYPE_VTG)
                    begin
                        hnd = HND_VTG;
                    end
                    else if (r.sentence_type == STYPE_RMC)
                    begin
                        hnd = HND_RMC;
                    end
                end
                bump_field();
                restart_buffer();
                r.event_res = EV_FIELD;
            end
            default:
            begin
                keep_char(c);
                if (!star_seen)
                begin
                    xor_sum = xor_sum ^ c;
                end
            end
        endcase
        if (r.event_res != EV_FIELD)
        begin
            r.field_index = field_no;
        end
        r.handler     = hnd;
        r.checksum_ok = verdict_q;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    // predict on every accepted character, check every accepted result word
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready === 1'b1)
        begin
            pending_results.push_back(parse_char(s_tdata));
        end
        if (m_tvalid === 1'b1 && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with none expected, expected none, actual %h/%h",
                         $time, m_tuser, m_tdata);
                n_errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("event_res", 32'(want.event_res), 32'(m_tuser));
                compare_field("field_index", 32'(want.field_index), 32'(m_tdata[5:0]));
                compare_field("sentence_type", 32'(want.sentence_type), 32'(m_tdata[8:6]));
                compare_field("handler", 32'(want.handler), 32'(m_tdata[10:9]));
                compare_field("checksum_ok", 32'(want.checksum_ok), 32'(m_tdata[11]));
                compare_field("out_byte", 32'(want.out_byte), 32'(m_tdata[19:12]));
                compare_field("pad", 32'd0, 32'(m_tdata[23:20]));
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
        begin
            idle_count <= 0;
        end
        else
        begin
            idle_count <= idle_count + 1;
        end
        if (idle_count >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side backpressure in random bursts
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // one character word, with an optional idle burst ahead of it
    task automatic send_char(input logic [7:0] c);
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (s_tready !== 1'b1)
        begin
            @(posedge clk);
        end
        n_sent++;
    endtask

    task automatic send_line();
        foreach (line_q[i])
        begin
            send_char(line_q[i]);
        end
        line_q.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            line_q.push_back(s[i]);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
        begin
            return CHAR_ZERO + {4'd0, n};
        end
        // 'A' - 10 or 'a' - 10
        return (lower ? 8'h57 : 8'h37) + {4'd0, n};
    endfunction

    // append '*', the checksum in one of several spellings, '\r' and mostly '\n'
    task automatic close_sentence(input bit good);
        logic [7:0] sum;
        int         form;
        bit         lower;
        sum = 8'h00;
        for (int i = 1; i < line_q.size(); i++)
        begin
            sum ^= line_q[i];
        end
        if (!good)
        begin
            sum ^= 8'($urandom_range(1, 255));
        end
        form  = $urandom_range(0, 3);
        lower = 1'($urandom_range(0, 1));
        line_q.push_back(CHAR_STAR);
        if (form == 1)
        begin
            line_q.push_back(CHAR_ZERO);
        end
        line_q.push_back(hex_char(sum[7:4], lower));
        line_q.push_back(hex_char(sum[3:0], lower));
        // a zero byte freezes the value, later digits must not count
        if (form == 2)
        begin
            line_q.push_back(NUL_BYTE);
            line_q.push_back(hex_char(4'($urandom_range(0, 15)), lower));
        end
        line_q.push_back(CHAR_CR);
        if ($urandom_range(0, 7) != 0)
        begin
            line_q.push_back(CHAR_LF);
        end
    endtask

    function automatic logic [7:0] field_char();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
        begin
            return field_chars[$urandom_range(0, 15)];
        end
        if (pick < 18)
        begin
            return 8'($urandom_range(8'h41, 8'h5A)) | (pick[0] ? 8'h20 : 8'h00);
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // one random sentence, noise run or broken line into line_q
    task automatic build_sentence();
        logic [23:0] code;
        int          pick;
        int          n_fields;
        int          len;
        int          cut;
        if ($urandom_range(0, 11) == 0)
        begin
            repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        line_q.push_back(CHAR_DOLLAR);
        pick = $urandom_range(0, 6);
        if (pick == 6)
        begin
            // short header, type letters never complete
            repeat ($urandom_range(0, 4)) line_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
        end
        else
        begin
            case (pick)
                0:       code = CODE_GGA;
                1:       code = CODE_GSV;
                2:       code = CODE_VTG;
                3:       code = CODE_RMC;
                4:       code = CODE_GSA;
                default: code = {8'($urandom_range(8'h41, 8'h5A)),
                                 8'($urandom_range(8'h41, 8'h5A)),
                                 8'($urandom_range(8'h41, 8'h5A))};
            endcase
            if ($urandom_range(0, 3) != 0)
            begin
                push_text("GP");
            end
            else
            begin
                repeat (2) line_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
            end
            line_q.push_back(code[7:0]);
            line_q.push_back(code[15:8]);
            line_q.push_back(code[23:16]);
        end
        n_fields = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70)
                                                 : $urandom_range(0, 10);
        repeat (n_fields)
        begin
            line_q.push_back(CHAR_COMMA);
            len = ($urandom_range(0, 79) == 0) ? $urandom_range(120, 135)
                                                : $urandom_range(0, 7);
            repeat (len) line_q.push_back(field_char());
        end
        close_sentence($urandom_range(0, 4) != 0);
        // broken line: cut anywhere after the start
        if ($urandom_range(0, 9) == 0)
        begin
            cut = $urandom_range(1, line_q.size());
            while (line_q.size() > cut)
            begin
                void'(line_q.pop_back());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_lone_bytes();
        gap_pct   = 30;
        stall_pct = 30;
        send_char(NUL_BYTE);
        send_char(8'hFF);
        send_char(CHAR_LF);
        send_char(CHAR_CR);
    endtask

    task automatic test_good_gga();
        push_text("$GPGGA,");
        close_sentence(1'b1);
        send_line();
    endtask

    task automatic test_short_header_zero_byte();
        push_text("$G,");
        line_q.push_back(NUL_BYTE);
        line_q.push_back(8'h35);
        line_q.push_back(CHAR_CR);
        send_line();
    endtask

    task automatic test_random_sentences();
        while (n_sent < 1600)
        begin
            gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
            build_sentence();
            send_line();
        end
    endtask

    task automatic test_full_rate();
        quiet = 1'b1;
        while (n_sent < 1850)
        begin
            build_sentence();
            send_line();
        end
    endtask

    task automatic drain_and_report();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (n_errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_lone_bytes();
        test_good_gga();
        test_short_header_zero_byte();
        test_random_sentences();
        test_full_rate();
        drain_and_report();
    end

endmodule

[nmea_sentence_byte_parser_core.f]
hw/rtl/nsp_pkg.sv
hw/rtl/nsp_step.sv
hw/rtl/nmea_sentence_byte_parser_core.sv
test/tb_nmea_sentence_byte_parser_core.sv
